/* rtl/ssns_pkg.sv */
// Shared types, constants and the segment decoder for the seven-segment number scan unit.
package ssns_pkg;

  // Field widths of the input and result beats
  localparam int unsigned WHOLE_W    = 16;
  localparam int unsigned FRAC_W     = 10;
  localparam int unsigned NDIG_W     = 3;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned NUM_SRC    = 7;   // four whole digits, three fraction digits
  localparam int unsigned NUM_LEAD   = 3;   // leading positions that may be blanked

  // Saturation limits
  localparam int unsigned WHOLE_MAX  = 9999;
  localparam int unsigned FRAC_MAX   = 999;
  localparam int unsigned NDIG_MAX   = 3;

  // Reduced widths after saturation
  localparam int unsigned WSAT_W     = 14;  // holds 9999
  localparam int unsigned HUND_W     = 7;   // holds 0..99
  localparam int unsigned DIG_W      = 4;

  // Reciprocal constants: x / 100 = (x * MUL) >> SH over the saturated ranges
  localparam int unsigned DIV100W_MUL = 5243;
  localparam int unsigned DIV100W_SH  = 19;
  localparam int unsigned DIV100W_PW  = 27;
  localparam int unsigned DIV100F_MUL = 41;
  localparam int unsigned DIV100F_SH  = 12;
  localparam int unsigned DIV100F_PW  = 16;
  localparam int unsigned DIV10_MUL   = 205;
  localparam int unsigned DIV10_SH    = 11;
  localparam int unsigned DIV10_PW    = 15;

  localparam logic [SEL_W-1:0] LAST_SEL = SEL_W'(NUM_DIGITS - 1);
  localparam logic [SEG_W-1:0] SEG_BLANK = '0;

  // Per-item control that rides along with the digits
  typedef struct packed {
    logic             fmode;
    logic [1:0]       ndig;   // clamped fraction digit count
    logic             ovf;
  } ctrl_t;

  // Seven decimal digits of one number, as handed to the frame unit
  typedef struct packed {
    logic [NUM_SRC-1:0][DIG_W-1:0] digit;
    ctrl_t                         ctrl;
  } digits_t;

  // Segments a..g in bits 0..6
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

/* rtl/ssns_if.sv */
// Valid/ready channel interfaces for number beats in and scan-frame beats out.
interface ssns_in_if;
  import ssns_pkg::*;

  logic              valid;
  logic              ready;
  logic [WHOLE_W-1:0] whole_part;
  logic [FRAC_W-1:0]  fraction_part;
  logic [NDIG_W-1:0]  fraction_digits;
  logic               show_point;

  modport source (output valid, whole_part, fraction_part, fraction_digits, show_point,
                  input ready);
  modport sink   (input valid, whole_part, fraction_part, fraction_digits, show_point,
                  output ready);
endinterface

interface ssns_out_if;
  import ssns_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] digit_select;
  logic [SEG_W-1:0] segment_bits;
  logic             point_lit;
  logic             point_driven;
  logic             overflow;
  logic             last_frame;

  modport source (output valid, digit_select, segment_bits, point_lit, point_driven,
                  overflow, last_frame, input ready);
  modport sink   (input valid, digit_select, segment_bits, point_lit, point_driven,
                  overflow, last_frame, output ready);
endinterface

/* rtl/ssns_digits.sv */
// Five-stage pipeline that saturates a number and splits it into seven decimal digits.
module ssns_digits (
  input  logic             clk,
  input  logic             rst_n,
  ssns_in_if.sink          in_ch,
  output logic             dig_valid,
  input  logic             dig_ready,
  output ssns_pkg::digits_t dig
);
  import ssns_pkg::*;

  // Stage valid bits and the ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || dig_ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: saturate whole and fraction, clamp digit count
  logic [WSAT_W-1:0] s1_w_r, s1_w_nxt;
  logic [FRAC_W-1:0] s1_f_r, s1_f_nxt;
  ctrl_t             s1_c_r, s1_c_nxt;

  always_comb begin
    s1_c_nxt.fmode = in_ch.show_point;
    s1_c_nxt.ovf   = (in_ch.whole_part > WHOLE_W'(WHOLE_MAX));
    s1_w_nxt = s1_c_nxt.ovf ? WSAT_W'(WHOLE_MAX) : in_ch.whole_part[WSAT_W-1:0];
    s1_f_nxt = (in_ch.fraction_part > FRAC_W'(FRAC_MAX)) ? FRAC_W'(FRAC_MAX)
                                                          : in_ch.fraction_part;
    s1_c_nxt.ndig = (in_ch.fraction_digits > NDIG_W'(NDIG_MAX)) ? 2'(NDIG_MAX)
                                                                 : in_ch.fraction_digits[1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_w_r <= s1_w_nxt;
      s1_f_r <= s1_f_nxt;
      s1_c_r <= s1_c_nxt;
    end
  end

  // Stage 2: divide both parts by 100 through reciprocal products
  logic [DIV100W_PW-1:0] prod_w;
  logic [DIV100F_PW-1:0] prod_f;
  logic [WSAT_W-1:0]     s2_w_r;
  logic [FRAC_W-1:0]     s2_f_r;
  logic [HUND_W-1:0]     s2_q_r;
  logic [DIG_W-1:0]      s2_fq_r;
  ctrl_t                 s2_c_r;

  assign prod_w = DIV100W_PW'(s1_w_r) * DIV100W_PW'(DIV100W_MUL);
  assign prod_f = DIV100F_PW'(s1_f_r) * DIV100F_PW'(DIV100F_MUL);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_w_r  <= s1_w_r;
      s2_f_r  <= s1_f_r;
      s2_q_r  <= HUND_W'(prod_w >> DIV100W_SH);
      s2_fq_r <= DIG_W'(prod_f >> DIV100F_SH);
      s2_c_r  <= s1_c_r;
    end
  end

  // Stage 3: remainders mod 100, thousands digit from the hundreds quotient
  logic [DIV10_PW-1:0] prod_q;
  logic [HUND_W-1:0]   s3_q_r, s3_lo_r, s3_fr_r;
  logic [DIG_W-1:0]    s3_d0_r, s3_d4_r;
  ctrl_t               s3_c_r;

  assign prod_q = DIV10_PW'(s2_q_r) * DIV10_PW'(DIV10_MUL);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_q_r  <= s2_q_r;
      s3_d0_r <= DIG_W'(prod_q >> DIV10_SH);
      s3_lo_r <= HUND_W'(s2_w_r - WSAT_W'(s2_q_r) * WSAT_W'(100));
      s3_fr_r <= HUND_W'(s2_f_r - FRAC_W'(s2_fq_r) * FRAC_W'(100));
      s3_d4_r <= s2_fq_r;
      s3_c_r  <= s2_c_r;
    end
  end

  // Stage 4: hundreds digit, tens of both two-digit remainders
  logic [DIV10_PW-1:0] prod_lo, prod_fr;
  logic [DIG_W-1:0]    s4_d0_r, s4_d1_r, s4_d2_r, s4_d4_r, s4_d5_r;
  logic [HUND_W-1:0]   s4_lo_r, s4_fr_r;
  ctrl_t               s4_c_r;

  assign prod_lo = DIV10_PW'(s3_lo_r) * DIV10_PW'(DIV10_MUL);
  assign prod_fr = DIV10_PW'(s3_fr_r) * DIV10_PW'(DIV10_MUL);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_d0_r <= s3_d0_r;
      s4_d1_r <= DIG_W'(s3_q_r - HUND_W'(s3_d0_r) * HUND_W'(10));
      s4_d2_r <= DIG_W'(prod_lo >> DIV10_SH);
      s4_d4_r <= s3_d4_r;
      s4_d5_r <= DIG_W'(prod_fr >> DIV10_SH);
      s4_lo_r <= s3_lo_r;
      s4_fr_r <= s3_fr_r;
      s4_c_r  <= s3_c_r;
    end
  end

  // Stage 5: units digits, full digit set out
  digits_t s5_r, s5_nxt;

  always_comb begin
    s5_nxt.digit[0] = s4_d0_r;
    s5_nxt.digit[1] = s4_d1_r;
    s5_nxt.digit[2] = s4_d2_r;
    s5_nxt.digit[3] = DIG_W'(s4_lo_r - HUND_W'(s4_d2_r) * HUND_W'(10));
    s5_nxt.digit[4] = s4_d4_r;
    s5_nxt.digit[5] = s4_d5_r;
    s5_nxt.digit[6] = DIG_W'(s4_fr_r - HUND_W'(s4_d5_r) * HUND_W'(10));
    s5_nxt.ctrl     = s4_c_r;
  end

  always_ff @(posedge clk) begin
    if (rdy5) s5_r <= s5_nxt;
  end

  assign dig_valid = v5_r;
  assign dig       = s5_r;

endmodule

/* rtl/ssns_frame.sv */
// Window selection, leading-zero blanking and the four-beat frame output register.
module ssns_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              zero_lead,
  input  logic              dig_valid,
  output logic              dig_ready,
  input  ssns_pkg::digits_t dig,
  ssns_out_if.source        out_ch
);
  import ssns_pkg::*;

  logic                             busy_r;
  logic [SEL_W-1:0]                 cnt_r;
  logic [NUM_DIGITS-1:0][SEG_W-1:0] segs_r, segs_nxt;
  logic [NUM_DIGITS-1:0]            pt_r, pt_nxt;
  logic                             fm_r, ov_r;
  logic                             out_beat, load;
  logic [NUM_SRC-1:0]               blank;
  logic [2:0]                       shift;
  logic [2:0]                       src;

  assign out_beat  = busy_r && out_ch.ready;
  assign dig_ready = !busy_r || (out_ch.ready && cnt_r == LAST_SEL);
  assign load      = dig_valid && dig_ready;

  // Blank chain over the three leading whole positions; units never blank
  always_comb begin
    blank    = '0;
    blank[0] = (dig.digit[0] == '0);
    blank[1] = blank[0] && (dig.digit[1] == '0);
    blank[2] = blank[1] && (dig.digit[2] == '0);
  end

  // Pick the four displayed positions and decode them
  always_comb begin
    shift = dig.ctrl.fmode ? {1'b0, dig.ctrl.ndig} : 3'd0;
    src   = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      src = 3'(k) + shift;
      if (blank[src] && !zero_lead)
        segs_nxt[k] = SEG_BLANK;
      else if (blank[src])
        segs_nxt[k] = seg_of('0);
      else
        segs_nxt[k] = seg_of(dig.digit[src]);
      pt_nxt[k] = dig.ctrl.fmode && (2'(k) == 2'(LAST_SEL - SEL_W'(dig.ctrl.ndig)));
    end
  end

  // Frame register and beat counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (out_beat) begin
      if (cnt_r == LAST_SEL) busy_r <= 1'b0;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      segs_r <= segs_nxt;
      pt_r   <= pt_nxt;
      fm_r   <= dig.ctrl.fmode;
      ov_r   <= dig.ctrl.ovf;
    end
  end

  assign out_ch.valid        = busy_r;
  assign out_ch.digit_select = cnt_r;
  assign out_ch.segment_bits = segs_r[cnt_r];
  assign out_ch.point_lit    = pt_r[cnt_r];
  assign out_ch.point_driven = fm_r;
  assign out_ch.overflow     = ov_r;
  assign out_ch.last_frame   = (cnt_r == LAST_SEL);

endmodule

/* rtl/seven_segment_number_scan_unit.sv */
// Top level of the seven-segment number scan unit: digit pipeline, frame unit, zero_lead register.
//
//  channel | dir | handshake      | beat
//  --------+-----+----------------+-------------------------------------------------
//  in_ch   | in  | valid/ready    | whole_part, fraction_part, fraction_digits, show_point
//  out_ch  | out | valid/ready    | one scan frame; four beats per number
//  cfg_    | in  | cfg_we         | cfg_wdata -> zero_lead
//
// A number passes five pipeline stages (saturate, /100, %100 and /10, /10, %10), then the
// frame register emits four beats, one per cycle while out_ch is ready. The pipeline takes
// new numbers while earlier ones are framed; the next loads as the last beat is taken.
// Reset (rst_n low, synchronous) empties the pipeline and clears zero_lead.
// A stall on out_ch backs up through the stages without losing or repeating a beat.
module seven_segment_number_scan_unit (
  input  logic       clk,
  input  logic       rst_n,
  ssns_in_if.sink    in_ch,
  ssns_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import ssns_pkg::*;

  logic    zero_lead_r;
  logic    dig_valid, dig_ready;
  digits_t dig;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) zero_lead_r <= 1'b0;
    else if (cfg_we) zero_lead_r <= cfg_wdata;
  end

  ssns_digits u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig)
  );

  ssns_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .zero_lead (zero_lead_r),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/ssns_checker.sv */
// Port-level checks on the scan-frame output of the seven-segment number scan unit.
module ssns_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] digit_select,
  input logic [6:0] segment_bits,
  input logic       point_lit,
  input logic       point_driven,
  input logic       last_frame
);

  // last marker sits on the rightmost position only
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_frame == (digit_select == 2'd3)))
    else $error("last_frame does not match digit_select");

  // frames of one scan follow one another left to right without a gap
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_frame) |=>
      (out_valid && digit_select == 2'($past(digit_select) + 2'd1)))
    else $error("scan frames out of order");

  // a point is only lit in fraction mode
  a_point_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && point_lit) |-> point_driven)
    else $error("point lit while not driven");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(segment_bits) && $stable(digit_select)))
    else $error("stalled beat changed");

endmodule

bind seven_segment_number_scan_unit ssns_checker u_ssns_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .digit_select (out_ch.digit_select),
  .segment_bits (out_ch.segment_bits),
  .point_lit    (out_ch.point_lit),
  .point_driven (out_ch.point_driven),
  .last_frame   (out_ch.last_frame)
);

/* bench/ssns_scan_checker.sv */
// Scoreboard for the seven-segment number scan unit: predicts scan frames and checks out_ch.
module ssns_scan_checker (
  input  logic clk,
  input  logic rst_n,
  ssns_in_if   in_mon,
  ssns_out_if  out_mon,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   fail_count,
  output int   frames_pending
);
  import ssns_pkg::*;

  typedef struct packed {
    logic [SEL_W-1:0] digit_select;
    logic [SEG_W-1:0] segment_bits;
    logic             point_lit;
    logic             point_driven;
    logic             overflow;
    logic             last_frame;
  } scan_frame_t;

  // Segment patterns for 9 down to 0, a..g in bits 0..6
  localparam logic [9:0][SEG_W-1:0] DIGIT_FONT = {
    7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  scan_frame_t expected_frames[$];
  logic        zero_lead_q;
  int          frames_seen;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Four scan frames for one number beat, queued in display order
  function automatic void predict_scan(input logic [WHOLE_W-1:0] whole,
                                       input logic [FRAC_W-1:0]  frac,
                                       input logic [NDIG_W-1:0]  ndig,
                                       input logic               fmode);
    int unsigned w, f, n, shift, src;
    int unsigned digs[7];
    bit          blanked[7];
    logic        sat;
    scan_frame_t fr;
    w   = whole;
    f   = frac;
    sat = 1'b0;
    if (w > WHOLE_MAX) begin
      w   = WHOLE_MAX;
      sat = 1'b1;
    end
    if (f > FRAC_MAX) f = FRAC_MAX;
    digs[0] = w / 1000;
    digs[1] = (w / 100) % 10;
    digs[2] = (w / 10) % 10;
    digs[3] = w % 10;
    digs[4] = f / 100;
    digs[5] = (f / 10) % 10;
    digs[6] = f % 10;
    // leading zeros of the whole part, never the units digit
    foreach (blanked[i]) blanked[i] = 1'b0;
    blanked[0] = (digs[0] == 0);
    blanked[1] = blanked[0] && (digs[1] == 0);
    blanked[2] = blanked[1] && (digs[2] == 0);
    n     = (ndig > NDIG_MAX) ? NDIG_MAX : ndig;
    shift = fmode ? n : 0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      src = (k + shift) % NUM_SRC;
      fr.digit_select = SEL_W'(k);
      if (blanked[src] && !zero_lead_q) fr.segment_bits = '0;
      else if (blanked[src])            fr.segment_bits = DIGIT_FONT[0];
      else                              fr.segment_bits = DIGIT_FONT[digs[src]];
      fr.point_lit    = fmode && (k == NDIG_MAX - n);
      fr.point_driven = fmode;
      fr.overflow     = sat;
      fr.last_frame   = (k == NUM_DIGITS - 1);
      expected_frames.push_back(fr);
    end
  endfunction

  // Sampled at the rising edge, before any beat driven at this edge settles
  always @(posedge clk) begin
    scan_frame_t want;
    if (!rst_n) begin
      zero_lead_q = 1'b0;
      fail_count  = 0;
      frames_seen = 0;
      expected_frames.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("frame %0d arrived with nothing expected", frames_seen));
        end else begin
          want = expected_frames.pop_front();
          if (out_mon.digit_select !== want.digit_select)
            report_mismatch($sformatf("frame %0d digit_select %0d, want %0d", frames_seen,
                                      out_mon.digit_select, want.digit_select));
          if (out_mon.segment_bits !== want.segment_bits)
            report_mismatch($sformatf("frame %0d segment_bits %h, want %h", frames_seen,
                                      out_mon.segment_bits, want.segment_bits));
          if (out_mon.point_lit !== want.point_lit)
            report_mismatch($sformatf("frame %0d point_lit %b, want %b", frames_seen,
                                      out_mon.point_lit, want.point_lit));
          if (out_mon.point_driven !== want.point_driven)
            report_mismatch($sformatf("frame %0d point_driven %b, want %b", frames_seen,
                                      out_mon.point_driven, want.point_driven));
          if (out_mon.overflow !== want.overflow)
            report_mismatch($sformatf("frame %0d overflow %b, want %b", frames_seen,
                                      out_mon.overflow, want.overflow));
          if (out_mon.last_frame !== want.last_frame)
            report_mismatch($sformatf("frame %0d last_frame %b, want %b", frames_seen,
                                      out_mon.last_frame, want.last_frame));
        end
        frames_seen++;
      end
      if (in_mon.valid && in_mon.ready)
        predict_scan(in_mon.whole_part, in_mon.fraction_part, in_mon.fraction_digits,
                     in_mon.show_point);
      if (cfg_we) zero_lead_q = cfg_wdata;
    end
    frames_pending = expected_frames.size();
  end

endmodule

/* bench/seven_segment_number_scan_unit_tb.sv */
// Testbench top for the seven-segment number scan unit: clock, reset, stimulus and verdict.
module seven_segment_number_scan_unit_tb;
  import ssns_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   fail_count;
  int   frames_pending;

  // idling knobs: the _pct ones in cycles per hundred, long_hold_cycles in cycles
  int   send_idle_pct;
  int   recv_stall_pct;
  int   long_hold_cycles;
  int   hold_left;

  ssns_in_if  in_ch ();
  ssns_out_if out_ch ();

  seven_segment_number_scan_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ssns_scan_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .frames_pending (frames_pending)
  );

  always #5 clk = ~clk;

  // Frame receiver: random stalls, or a long hold-off when one is requested
  initial begin
    bit hold_taken;
    hold_taken   = 1'b0;
    out_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (long_hold_cycles != 0 && !hold_taken) begin
        hold_left  = long_hold_cycles;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // One number beat, after a random idle gap
  task automatic send_number(input logic [WHOLE_W-1:0] whole, input logic [FRAC_W-1:0] frac,
                             input logic [NDIG_W-1:0] ndig, input logic show_pt);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.whole_part      <= whole;
    in_ch.fraction_part   <= frac;
    in_ch.fraction_digits <= ndig;
    in_ch.show_point      <= show_pt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Mostly in-range numbers, with saturating whole and fraction parts mixed in
  task automatic send_random_number();
    int unsigned         pick;
    logic [WHOLE_W-1:0]  whole;
    logic [FRAC_W-1:0]   frac;
    pick = $urandom_range(99);
    if (pick < 15)      whole = WHOLE_W'($urandom_range(99));
    else if (pick < 55) whole = WHOLE_W'($urandom_range(WHOLE_MAX));
    else if (pick < 75) whole = WHOLE_W'($urandom_range(65535, WHOLE_MAX + 1));
    else                whole = WHOLE_W'($urandom());
    if ($urandom_range(99) < 75) frac = FRAC_W'($urandom_range(FRAC_MAX));
    else                         frac = FRAC_W'($urandom_range(1023));
    send_number(whole, frac, NDIG_W'($urandom_range(7)), 1'($urandom_range(1)));
  endtask

  // Sender stops and waits for every frame, plus the pipeline depth
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_zero_lead(input logic value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.whole_part      = '0;
    in_ch.fraction_part   = '0;
    in_ch.fraction_digits = '0;
    in_ch.show_point      = 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    long_hold_cycles      = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: blanking, clamps, saturation, point placement; zero_lead from reset
    send_number(0, 0, 0, 1'b0);
    send_number(7, 5, 2, 1'b0);
    send_number(12, 0, 7, 1'b1);
    send_number(105, 250, 1, 1'b1);
    send_number(1000, 999, 3, 1'b1);
    send_number(9999, 999, 0, 1'b1);
    send_number(10000, 0, 2, 1'b1);
    send_number(16'hFFFF, 10'h3FF, 3'h7, 1'b1);
    send_number(0, 1000, 3, 1'b1);
    send_number(0, 5, 3, 1'b1);
    send_number(4321, 678, 4, 1'b0);
    send_number(8, 1, 5, 1'b1);
    wait_drained();
    write_zero_lead(1'b1);
    send_number(0, 0, 0, 1'b0);
    send_number(7, 0, 0, 1'b1);
    send_number(56, 90, 1, 1'b1);
    send_number(305, 7, 2, 1'b1);
    send_number(9, 512, 6, 1'b1);
    send_number(40000, 333, 3, 1'b0);
    send_number(0, 999, 3, 1'b1);
    send_number(1, 0, 0, 1'b0);

    // random phases, one idling pattern each, zero_lead alternating
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      write_zero_lead(phase[0]);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int n = 0; n < 98; n++) begin
        // back up the pipeline while beats keep coming (phase 0); drain once midway (phase 1)
        if (phase == 0 && n == 40) long_hold_cycles = 150;
        if (phase == 1 && n == 50) wait_drained();
        send_random_number();
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit, well beyond the slowest legal run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* seven_segment_number_scan_unit.f */
rtl/ssns_pkg.sv
rtl/ssns_if.sv
rtl/ssns_digits.sv
rtl/ssns_frame.sv
rtl/seven_segment_number_scan_unit.sv
rtl/ssns_checker.sv
bench/ssns_scan_checker.sv
bench/seven_segment_number_scan_unit_tb.sv
